// ----- sv/table_lfo_modulator_top_assert.svh -----
// Assertion macros shared by the checker of the wavetable LFO block.
`ifndef TABLE_LFO_MODULATOR_TOP_ASSERT_SVH
`define TABLE_LFO_MODULATOR_TOP_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define TLM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("table_lfo_modulator_top: check failed");

// Next-cycle implication under an active-low reset.
`define TLM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("table_lfo_modulator_top: check failed");

`endif

// ----- sv/tlm_pkg.sv -----
`timescale 1ns / 1ps
package tlm_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WAVE_TYPE   = 3'd0,
    CFG_RUN_MODE    = 3'd1,
    CFG_SPEED       = 3'd2,
    CFG_PAT_LEN     = 3'd3,
    CFG_TRIG_MASK   = 3'd4,
    CFG_LANE_ENABLE = 3'd5,
    CFG_DEPTH_A     = 3'd6,
    CFG_DEPTH_B     = 3'd7
  } cfg_idx_e;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [2:0] WAVE_INV_RAMP = 3'd4;
  localparam logic [2:0] WAVE_EXP      = 3'd5;

  localparam logic [1:0] RUN_FREE    = 2'd0;
  localparam logic [1:0] RUN_ONESHOT = 2'd2;

  localparam logic [3:0] CPH_FIRST = 4'd0;
  localparam logic [3:0] CPH_LAST  = 4'd11;

  localparam int FifoDepth = 8;
  localparam int FifoAw    = 3;

  typedef struct packed {
    logic       lane;
    logic [6:0] value;
    logic       last;
  } out_item_t;

endpackage

// ----- sv/table_lfo_modulator_top.sv -----
`timescale 1ns / 1ps
// Path: the first result item of a tick is offered once the tick has passed the wave memory
// read register, the stage 2 registers and the result queue; a second follows if both lanes emit.
// Throughput: one item per cycle while the 8-entry result queue holds items and out_stall_i is
// low; the two results of a tick leave one after the other through the single result port.
// Reset: configuration to defaults, phase, prescaler and step to zero, last values to 255,
// queue empty. The wave memory is not cleared and must be loaded before use.
module table_lfo_modulator_top #(
  parameter int PHASE_STEPS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tlm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [3:0]                   clock_phase_i,
  input  logic [6:0]                   base_a_i,
  input  logic [6:0]                   base_b_i,
  input  logic [1:0]                   table_select_i,
  input  logic [7:0]                   table_index_i,
  input  logic [7:0]                   table_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         lane_o,
  output logic [6:0]                   mod_value_o,
  output logic                         last_o
);
  import tlm_pkg::*;

  localparam int              PhW    = $clog2(PHASE_STEPS + 1);
  localparam logic [PhW-1:0]  PsP    = PhW'(PHASE_STEPS);
  localparam logic [PhW-1:0]  PsLast = PhW'(PHASE_STEPS - 1);
  localparam logic [7:0]      PsW    = 8'(PHASE_STEPS);

  // Configuration registers.
  logic [2:0]  wave_type_q;
  logic [1:0]  run_mode_q;
  logic [6:0]  speed_q;
  logic [6:0]  pat_len_q;
  logic [63:0] trig_mask_q;
  logic [1:0]  lane_en_q;
  logic [6:0]  depth_a_q;
  logic [6:0]  depth_b_q;

  // Sequencer state.
  logic [PhW-1:0] phase_q, phase_d;
  logic [7:0]     hold_q, hold_d;
  logic [5:0]     step_q, step_d;
  logic [7:0]     last_a_q, last_a_d;
  logic [7:0]     last_b_q, last_b_d;

  // Wave memory.
  logic [7:0] wave_mem [256];
  logic [7:0] rdata_q;
  logic [7:0] raddr, waddr;
  logic       wr_en, tick_acc;

  // Pipeline.
  logic               s1_v_q, s2_v_q;
  logic [6:0]         s1_base_a_q, s1_base_b_q;
  logic [6:0]         s2_base_a_q, s2_base_b_q;
  logic signed [16:0] s2_prod_a_q, s2_prod_b_q;
  logic signed [8:0]  s1_sample;
  logic signed [16:0] s1_prod_a, s1_prod_b;

  // Result queue.
  out_item_t         fifo_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   cnt_q, cnt_d;
  logic [FifoAw+1:0] need;

  logic           in_acc, pop;
  logic           restart, advance;
  logic [PhW-1:0] phase_cur, phase_inc;
  logic [7:0]     hold_inc;
  logic [1:0]     tbl_sel;
  logic [6:0]     val_a, val_b;
  logic           emit_a, emit_b;

  function automatic logic [6:0] lane_calc(input logic signed [16:0] p,
                                           input logic [6:0] b);
    logic signed [16:0] adj;
    logic signed [9:0]  q;
    logic signed [9:0]  v;
    // Bias negative products so the shift truncates toward zero.
    adj = p + (p[16] ? 17'sd127 : 17'sd0);
    q   = 10'(adj >>> 7);
    v   = q + $signed({3'b000, b});
    if (v < 10'sd0) begin
      return 7'd0;
    end else if (v > 10'sd127) begin
      return 7'd127;
    end
    return v[6:0];
  endfunction

  assign in_acc   = in_valid_i && !in_stall_o;
  assign tick_acc = in_acc && (op_i == OP_TICK);
  assign wr_en    = in_acc && (op_i == OP_WRITE) && (table_index_i < PsW);
  assign waddr    = 8'(32'(table_select_i) * PHASE_STEPS) + table_index_i;

  // Every tick in flight may still push two results; hold off input until the queue
  // can take all of them.
  assign need = (FifoAw+2)'(cnt_q) + (FifoAw+2)'(2)
              + (s1_v_q ? (FifoAw+2)'(2) : '0) + (s2_v_q ? (FifoAw+2)'(2) : '0);
  assign in_stall_o = need > (FifoAw+2)'(FifoDepth);

  always_comb begin
    case (wave_type_q)
      WAVE_INV_RAMP: tbl_sel = 2'd2;
      WAVE_EXP:      tbl_sel = 2'd3;
      default:       tbl_sel = wave_type_q[1:0];
    endcase
  end

  always_comb begin
    restart   = (clock_phase_i == CPH_FIRST) && (run_mode_q != RUN_FREE)
                && trig_mask_q[step_q];
    phase_cur = restart ? '0 : phase_q;
    raddr     = 8'(32'(tbl_sel) * PHASE_STEPS) + 8'(phase_cur);

    hold_inc = hold_q + 8'd1;
    advance  = (speed_q == 7'd0) || (hold_inc >= (8'(speed_q) - 8'd1));
    if (speed_q == 7'd0) begin
      hold_d = hold_q;
    end else begin
      hold_d = advance ? 8'd0 : hold_inc;
    end
    phase_inc = advance ? phase_cur + PhW'(1) : phase_cur;
    if (phase_inc >= PsP) begin
      phase_d = (run_mode_q == RUN_ONESHOT) ? PsLast : '0;
    end else begin
      phase_d = phase_inc;
    end

    step_d = step_q;
    if (clock_phase_i == CPH_LAST) begin
      step_d = ({1'b0, step_q} == 7'(pat_len_q - 7'd1)) ? 6'd0 : step_q + 6'd1;
    end
  end

  // Stage 1: centre the sample (negate for INV_RAMP and EXP) and scale it by each lane's depth.
  always_comb begin
    if ((wave_type_q == WAVE_INV_RAMP) || (wave_type_q == WAVE_EXP)) begin
      s1_sample = -$signed({1'b0, rdata_q});
    end else if ((wave_type_q == WAVE_SINE) || (wave_type_q == WAVE_TRIANGLE)) begin
      s1_sample = $signed({1'b0, rdata_q}) - 9'sd64;
    end else begin
      s1_sample = $signed({1'b0, rdata_q}) - 9'sd128;
    end
    s1_prod_a = s1_sample * $signed({1'b0, depth_a_q});
    s1_prod_b = s1_sample * $signed({1'b0, depth_b_q});
  end

  // Stage 2: finish the lane values and drop those that did not change or whose lane is disabled.
  always_comb begin
    val_a    = lane_calc(s2_prod_a_q, s2_base_a_q);
    val_b    = lane_calc(s2_prod_b_q, s2_base_b_q);
    emit_a   = s2_v_q && lane_en_q[0] && ({1'b0, val_a} != last_a_q);
    emit_b   = s2_v_q && lane_en_q[1] && ({1'b0, val_b} != last_b_q);
    last_a_d = emit_a ? {1'b0, val_a} : last_a_q;
    last_b_d = emit_b ? {1'b0, val_b} : last_b_q;
    pop      = (cnt_q != '0) && !out_stall_i;
    cnt_d    = cnt_q + (FifoAw+1)'(emit_a) + (FifoAw+1)'(emit_b) - (FifoAw+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wave_mem[waddr] <= table_value_i;
    end
    if (tick_acc) begin
      rdata_q <= wave_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_base_a_q <= base_a_i;
      s1_base_b_q <= base_b_i;
    end
    if (s1_v_q) begin
      s2_prod_a_q <= s1_prod_a;
      s2_prod_b_q <= s1_prod_b;
      s2_base_a_q <= s1_base_a_q;
      s2_base_b_q <= s1_base_b_q;
    end
    if (emit_a && emit_b) begin
      fifo_q[wr_ptr_q]          <= '{lane: 1'b0, value: val_a, last: 1'b0};
      fifo_q[wr_ptr_q + 1'b1]   <= '{lane: 1'b1, value: val_b, last: 1'b1};
    end else if (emit_a) begin
      fifo_q[wr_ptr_q]          <= '{lane: 1'b0, value: val_a, last: 1'b1};
    end else if (emit_b) begin
      fifo_q[wr_ptr_q]          <= '{lane: 1'b1, value: val_b, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_type_q <= 3'd0;
      run_mode_q  <= 2'd0;
      speed_q     <= 7'd0;
      pat_len_q   <= 7'd16;
      trig_mask_q <= 64'd0;
      lane_en_q   <= 2'd0;
      depth_a_q   <= 7'd0;
      depth_b_q   <= 7'd0;
      phase_q     <= '0;
      hold_q      <= 8'd0;
      step_q      <= 6'd0;
      last_a_q    <= 8'd255;
      last_b_q    <= 8'd255;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WAVE_TYPE:   wave_type_q <= cfg_data_i[2:0];
          CFG_RUN_MODE:    run_mode_q  <= cfg_data_i[1:0];
          CFG_SPEED:       speed_q     <= cfg_data_i[6:0];
          CFG_PAT_LEN:     pat_len_q   <= cfg_data_i[6:0];
          CFG_TRIG_MASK:   trig_mask_q <= cfg_data_i;
          CFG_LANE_ENABLE: lane_en_q   <= cfg_data_i[1:0];
          CFG_DEPTH_A:     depth_a_q   <= cfg_data_i[6:0];
          CFG_DEPTH_B:     depth_b_q   <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (tick_acc) begin
        phase_q <= phase_d;
        hold_q  <= hold_d;
        step_q  <= step_d;
      end
      s1_v_q   <= tick_acc;
      s2_v_q   <= s1_v_q;
      last_a_q <= last_a_d;
      last_b_q <= last_b_d;
      wr_ptr_q <= wr_ptr_q + FifoAw'(emit_a) + FifoAw'(emit_b);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign lane_o      = fifo_q[rd_ptr_q].lane;
  assign mod_value_o = fifo_q[rd_ptr_q].value;
  assign last_o      = fifo_q[rd_ptr_q].last;

endmodule

// ----- sv/tlm_checker.sv -----
`timescale 1ns / 1ps
`include "table_lfo_modulator_top_assert.svh"
module tlm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [tlm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [tlm_pkg::CfgDataW-1:0] cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_stall_i,
  input logic                         in_op_i,
  input logic                         out_valid_i,
  input logic                         out_stall_i,
  input logic                         out_lane_i,
  input logic [6:0]                   out_mod_value_i,
  input logic                         out_last_i
);
  import tlm_pkg::*;

  logic cfg_seen;
  assign cfg_seen = cfg_we_i && (cfg_idx_i == cfg_idx_i) && (cfg_data_i == cfg_data_i);

  // A stalled result item stays on the port unchanged.
  `TLM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_lane_i) && $stable(out_mod_value_i) && $stable(out_last_i))

  // Only the first of a pair can be non-final, and that is always lane zero.
  `TLM_ASSERT_IMP(a_first_is_lane0, clk_i, rst_ni, out_valid_i && !out_last_i, !out_lane_i)

  // The second item of a pair is queued already when the first one leaves.
  `TLM_ASSERT_NXT(a_pair_follows, clk_i, rst_ni, out_valid_i && !out_stall_i && !out_last_i, out_valid_i && out_lane_i)

  // An empty output only fills from an accepted tick that has passed the read, stage 2 and queue registers.
  `TLM_ASSERT_IMP(a_result_from_tick, clk_i, rst_ni, $rose(out_valid_i) && !cfg_seen, $past(in_valid_i && !in_stall_i && (in_op_i == OP_TICK), 3))

endmodule

bind table_lfo_modulator_top tlm_checker u_tlm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_idx_i       (cfg_idx_i),
  .cfg_data_i      (cfg_data_i),
  .in_valid_i      (in_valid_i),
  .in_stall_i      (in_stall_o),
  .in_op_i         (op_i),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_lane_i      (lane_o),
  .out_mod_value_i (mod_value_o),
  .out_last_i      (last_o)
);
